FILE: hw/rtl/lsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_pkg
// Shared types and constants for the line substring matcher: item layouts,
// configuration register indexes and the configuration bundle.
// ----------------------------------------------------------------------------
package lsm_pkg;

  // Largest pattern the block is built for by default
  localparam int PATTERN_MAX_DEF = 16;
  // Pattern bytes held by the two 64-bit pattern registers
  localparam int PAT_BYTES       = 16;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_INDEX_W     = 3;
  localparam logic [7:0] NEWLINE = 8'd10;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PATTERN_FIRST = 3'd0,
    REG_PATTERN_LAST  = 3'd1,
    REG_PATTERN_LEN   = 3'd2,
    REG_FOLD_CASE     = 3'd3,
    REG_WORD_MODE     = 3'd4
  } reg_index_t;

  // One input item
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_t;

  // One result item
  typedef struct packed {
    logic [31:0] line_index;
    logic        line_matched;
    logic [31:0] matched_lines;
    logic        stream_done;
  } out_t;

  // Configuration bundle handed to the scan stage
  typedef struct packed {
    logic [PAT_BYTES-1:0][7:0] pattern;
    logic [4:0]                pattern_length;
    logic                      fold_case;
    logic                      word_mode;
  } cfg_t;

  // Scan stage outcome for the byte in flight
  typedef struct packed {
    logic eol;
    logic eos;
    logic hit;
  } scan_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lsm_scan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_scan
// Recent-byte window and per-line hit flag. Compares the pattern against
// the window after shifting in the current byte and, in word mode, also
// before it, all pattern bytes at once; reports line end and line hit.
// ----------------------------------------------------------------------------
module lsm_scan #(
  parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          advance,
  input  wire lsm_pkg::in_t  item,
  input  wire lsm_pkg::cfg_t cfg,
  output lsm_pkg::scan_t     result
);
  import lsm_pkg::*;

  localparam int DEPTH = PATTERN_MAX + 1;
  localparam int WIN_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef logic [DEPTH-1:0][7:0] win_t;

  // Newest byte at index 0
  win_t             window;
  logic [CNT_W-1:0] count;
  logic             line_hit;

  win_t             window_next;
  logic [CNT_W-1:0] count_next;
  logic [CNT_W-1:0] len;
  logic             eol;
  logic             pre_hit;
  logic             post_hit;
  logic             hit;

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    if (ic && c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // Pattern sits in win[len-1] (first byte) down to win[0] (last byte)
  function automatic logic win_match(input win_t win, input logic [CNT_W-1:0] cnt,
                                     input logic [CNT_W-1:0] l, input cfg_t c);
    logic             ok;
    logic [CNT_W-1:0] idx;
    ok = (cnt >= l);
    for (int i = 0; i < PATTERN_MAX; i++) begin
      idx = l - CNT_W'(i) - CNT_W'(1);
      if (CNT_W'(i) < l &&
          fold(win[idx[WIN_W-1:0]], c.fold_case) != fold(c.pattern[i], c.fold_case)) begin
        ok = 1'b0;
      end
    end
    return ok;
  endfunction

  // Match plus a left edge: line start or a non-alphanumeric byte
  function automatic logic word_match(input win_t win, input logic [CNT_W-1:0] cnt,
                                      input logic [CNT_W-1:0] l, input cfg_t c);
    return win_match(win, cnt, l, c) &&
           (cnt == l || !is_alnum(win[l[WIN_W-1:0]]));
  endfunction

  // Clamp the configured length into 1..PATTERN_MAX
  always_comb begin
    if (cfg.pattern_length == 5'd0) begin
      len = CNT_W'(1);
    end else if (cfg.pattern_length > 5'(PATTERN_MAX)) begin
      len = CNT_W'(PATTERN_MAX);
    end else begin
      len = CNT_W'(cfg.pattern_length);
    end
  end

  // Shift the window and compare after the shift (and before it in word mode)
  always_comb begin
    eol         = (item.data_byte == NEWLINE) || item.end_of_stream;
    window_next = {window[DEPTH-2:0], item.data_byte};
    count_next  = (count < CNT_W'(DEPTH)) ? count + CNT_W'(1) : count;
    pre_hit     = cfg.word_mode && word_match(window, count, len, cfg) &&
                  !is_alnum(item.data_byte);
    if (!cfg.word_mode) begin
      post_hit = win_match(window_next, count_next, len, cfg);
    end else begin
      post_hit = eol && word_match(window_next, count_next, len, cfg);
    end
    hit = line_hit || pre_hit || post_hit;
    result.eol = eol;
    result.eos = item.end_of_stream;
    result.hit = hit;
  end

  // Window contents need no reset: the fill count guards every read
  always_ff @(posedge clk) begin
    if (advance) begin
      window <= window_next;
    end
  end

  // Advance fill count and hit flag, restart both at a line end
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      line_hit <= 1'b0;
    end else if (advance) begin
      count    <= eol ? '0 : count_next;
      line_hit <= eol ? 1'b0 : hit;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lsm_tally.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsm_tally
// Line and match counters with saturation, and the result register that
// holds a finished item until the downstream side takes it.
// ----------------------------------------------------------------------------
module lsm_tally (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           advance,
  input  wire lsm_pkg::scan_t scan,
  output logic                room,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lsm_pkg::out_t       out_item
);
  import lsm_pkg::*;

  logic [31:0] line_count;
  logic [31:0] hit_counter;
  logic [31:0] total;
  logic        load;

  // Result register is free when empty or being taken this cycle
  always_comb begin
    room  = !out_valid || !out_stall;
    load  = advance && scan.eol;
    total = (scan.hit && hit_counter != '1) ? hit_counter + 32'd1 : hit_counter;
  end

  // Advance counters at each line end, restart them after end of stream
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count  <= 32'd1;
      hit_counter <= '0;
    end else if (load) begin
      if (scan.eos) begin
        line_count  <= 32'd1;
        hit_counter <= '0;
      end else begin
        line_count  <= (line_count != '1) ? line_count + 32'd1 : line_count;
        hit_counter <= total;
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_item.line_index    <= line_count;
      out_item.line_matched  <= scan.hit;
      out_item.matched_lines <= total;
      out_item.stream_done   <= scan.eos;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/line_substring_matcher.sv
`default_nettype none
// ----------------------------------------------------------------------------
// line_substring_matcher
// Fixed-string line search over a byte stream. Reports at every line end
// whether the line held the configured pattern, with line number and the
// running count of matching lines.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+--------------------------------------
//  in       | in_valid / in_stall    | in_item: data_byte, end_of_stream
//  out      | out_valid / out_stall  | out_item: line_index, line_matched,
//           |                        |   matched_lines, stream_done
//  config   | cfg_write              | cfg_index, cfg_data
//
//  One byte per cycle while no line end waits on a held result: input
//  register, combinational parallel window compares, then the result
//  register, loaded with each line end that leaves the input register.
//  Reset (rst, synchronous) empties both registers and restarts the line
//  and match counts; pattern length returns to 1.
//  A held result stalls only bytes that end a line; other bytes keep
//  flowing through the window behind it.
// ----------------------------------------------------------------------------
module line_substring_matcher #(
  parameter int PATTERN_MAX = lsm_pkg::PATTERN_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire lsm_pkg::in_t                   in_item,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output lsm_pkg::out_t                       out_item,
  input  wire logic                           cfg_write,
  input  wire logic [lsm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [lsm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lsm_pkg::*;

  cfg_t  cfg;
  logic  item_valid;
  in_t   item;
  logic  advance;
  logic  room;
  scan_t scan;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern        <= '0;
      cfg.pattern_length <= 5'd1;
      cfg.fold_case      <= 1'b0;
      cfg.word_mode      <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_PATTERN_FIRST: cfg.pattern[7:0]  <= cfg_data;
        REG_PATTERN_LAST:  cfg.pattern[15:8] <= cfg_data;
        REG_PATTERN_LEN:   cfg.pattern_length <= cfg_data[4:0];
        REG_FOLD_CASE:     cfg.fold_case <= cfg_data[0];
        REG_WORD_MODE:     cfg.word_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Move the held byte on unless it ends a line and the result is still held
  always_comb begin
    advance  = item_valid && (!scan.eol || room);
    in_stall = item_valid && !advance;
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item <= in_item;
    end
  end

  lsm_scan #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_scan (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .cfg     (cfg),
    .result  (scan)
  );

  lsm_tally u_tally (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .scan      (scan),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule
`default_nettype wire
